>>> rtl/core/pfsa_pkg.sv
// Package for the per-finger stiffness adaptation block.
// Holds the payload structs, register indexes, sizes and the controller state type.
// No dependencies.
package pfsa_pkg;

  localparam int FINGERS      = 4;
  localparam int THUMB_FINGER = 3;
  localparam int IDX_W        = (FINGERS > 4) ? $clog2(FINGERS) : 2;

  localparam int FORCE_W = 16;
  localparam int SQ_W    = 32;   // sum of three squares of Q8.8 values
  localparam int ROOT_W  = SQ_W / 2;
  localparam int STIFF_W = 35;
  localparam int ERR_W   = 19;
  localparam int PROD_W  = ERR_W + 32;
  localparam int ADJ_W   = PROD_W - 16;
  localparam int SUM_W   = STIFF_W + 2;

  localparam logic [1:0] CFG_FORCE_SETPOINT    = 2'd0;
  localparam logic [1:0] CFG_INITIAL_STIFFNESS = 2'd1;
  localparam logic [1:0] CFG_ADAPT_GAIN        = 2'd2;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_ACTIVITY = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic [1:0]                 finger;
    logic signed [FORCE_W-1:0]  force_x;
    logic signed [FORCE_W-1:0]  force_y;
    logic signed [FORCE_W-1:0]  force_z;
    logic                       activate;
  } in_item_t;

  typedef struct packed {
    logic               all_fingers;
    logic [1:0]         finger_out;
    logic [STIFF_W-1:0] stiffness;
    logic               spring_active;
    logic [ROOT_W-1:0]  force_magnitude;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_SQUARE,
    S_SUM,
    S_START,
    S_SQRT,
    S_MUL,
    S_CLAMP,
    S_EMIT
  } state_t;

endpackage

>>> rtl/core/pfsa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; used for the per-finger stiffness store.
module pfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pfsa_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on pfsa_pkg for the operand widths.
module pfsa_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfsa_pkg::SQ_W-1:0]   radicand,
  output logic                        done,
  output logic [pfsa_pkg::ROOT_W-1:0] root
);

  localparam int REM_W = pfsa_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(pfsa_pkg::ROOT_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [pfsa_pkg::SQ_W-1:0]  rad;
  logic [REM_W-1:0]           rem;
  logic [REM_W+1:0]           rem_t;
  logic [REM_W+1:0]           trial;
  logic                       fits;

  assign rem_t = {rem, rad[pfsa_pkg::SQ_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (int'(cnt) == pfsa_pkg::ROOT_W - 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Restoring method: bring down two radicand bits, try to subtract 4*root+1.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[pfsa_pkg::SQ_W-3:0], 2'b00};
      if (fits) begin
        rem  <= REM_W'(rem_t - trial);
        root <= {root[pfsa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_t[REM_W-1:0];
        root <= {root[pfsa_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/core/per_finger_stiffness_adaptation.sv
// Per-finger stiffness adaptation: top level with controller and update datapath.
// Depends on pfsa_pkg, pfsa_ram (stiffness store) and pfsa_sqrt (force magnitude).
//
// Usage:
//   in_valid/in_ready/in_item carry force samples and activity requests. One
//   transaction is taken at a time; in_ready is high only while the block idles.
//   out_valid/out_ready/out_item carry spring commands, held in an output
//   register, so a new transaction may be taken while a command waits there.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the target force, initial
//   stiffness and adaptation gain; cfg_ready is always high.
// Processing:
//   An activity request rewrites every finger entry of the stiffness RAM, one
//   entry a cycle, before its command. A force sample goes through the
//   squares, sum, 16 steps of the bit-serial square root, the gain multiply,
//   then the clamped read-modify-write of that finger's entry.
//   The next transaction is taken only once the controller is idle again.
//   Samples while inactive are dropped in the cycle they are taken.
// Reset clears the state, config registers, active flag and output valid; the RAM is
// written by the first activity request. When the receiver stalls, one command
// waits in the output register, the next finished command waits in the
// controller, and no further transaction is taken until the register frees.
module per_finger_stiffness_adaptation (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfsa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pfsa_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  pfsa_pkg::state_t state, state_next;

  logic [15:0]        force_setpoint;
  logic [31:0]        initial_stiffness;
  logic signed [31:0] adapt_gain;
  logic               active_flag;

  pfsa_pkg::in_item_t  item;
  pfsa_pkg::out_item_t res;

  logic [pfsa_pkg::IDX_W-1:0]         sweep_cnt;
  logic [2*pfsa_pkg::FORCE_W-2:0]     sq_x, sq_y, sq_z;
  logic [pfsa_pkg::SQ_W-1:0]          sum_sq;
  logic [pfsa_pkg::ROOT_W-1:0]        mag;
  logic signed [pfsa_pkg::ERR_W-1:0]  err;
  logic signed [pfsa_pkg::PROD_W-1:0] prod;
  logic [pfsa_pkg::STIFF_W-1:0]       kmax;

  logic [17:0]                         target3;
  logic signed [pfsa_pkg::ADJ_W-1:0]   adj;
  logic signed [pfsa_pkg::SUM_W-1:0]   k_sum;
  logic [pfsa_pkg::STIFF_W-1:0]        k_clamped;

  logic                               in_fire;
  logic                               take_sample;
  logic                               sweep_last;
  logic                               sqrt_start;
  logic                               sqrt_done;
  logic [pfsa_pkg::ROOT_W-1:0]        sqrt_root;
  logic                               out_free;

  logic                               ram_we;
  logic [pfsa_pkg::IDX_W-1:0]         ram_waddr;
  logic [pfsa_pkg::STIFF_W-1:0]       ram_wdata;
  logic [pfsa_pkg::IDX_W-1:0]         ram_raddr;
  logic [pfsa_pkg::STIFF_W-1:0]       ram_rdata;

  assign cfg_ready   = 1'b1;
  assign in_fire     = in_valid && in_ready;
  assign take_sample = active_flag && (int'(in_item.finger) < pfsa_pkg::FINGERS);
  assign sweep_last  = (int'(sweep_cnt) == pfsa_pkg::FINGERS - 1);
  assign out_free    = !out_valid || out_ready;
  assign ram_raddr   = pfsa_pkg::IDX_W'(item.finger);

  // ---------------------------------------------------------------- storage
  pfsa_ram #(
    .WIDTH (pfsa_pkg::STIFF_W),
    .DEPTH (pfsa_pkg::FINGERS)
  ) u_stiff_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfsa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum_sq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      force_setpoint    <= '0;
      initial_stiffness <= '0;
      adapt_gain        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfsa_pkg::CFG_FORCE_SETPOINT:    force_setpoint    <= cfg_data[15:0];
        pfsa_pkg::CFG_INITIAL_STIFFNESS: initial_stiffness <= cfg_data;
        pfsa_pkg::CFG_ADAPT_GAIN:        adapt_gain        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pfsa_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_item.operation == pfsa_pkg::OP_ACTIVITY) begin
            state_next = pfsa_pkg::S_SWEEP;
          end else if (take_sample) begin
            state_next = pfsa_pkg::S_SQUARE;
          end
        end
      end
      pfsa_pkg::S_SWEEP:  if (sweep_last) state_next = pfsa_pkg::S_EMIT;
      pfsa_pkg::S_SQUARE: state_next = pfsa_pkg::S_SUM;
      pfsa_pkg::S_SUM:    state_next = pfsa_pkg::S_START;
      pfsa_pkg::S_START:  state_next = pfsa_pkg::S_SQRT;
      pfsa_pkg::S_SQRT:   if (sqrt_done) state_next = pfsa_pkg::S_MUL;
      pfsa_pkg::S_MUL:    state_next = pfsa_pkg::S_CLAMP;
      pfsa_pkg::S_CLAMP:  state_next = pfsa_pkg::S_EMIT;
      pfsa_pkg::S_EMIT:   if (out_free) state_next = pfsa_pkg::S_IDLE;
      default:            state_next = pfsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    sqrt_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = sweep_cnt;
    ram_wdata  = pfsa_pkg::STIFF_W'(initial_stiffness);
    case (state)
      pfsa_pkg::S_IDLE:  in_ready = 1'b1;
      pfsa_pkg::S_SWEEP: ram_we = 1'b1;
      pfsa_pkg::S_START: sqrt_start = 1'b1;
      pfsa_pkg::S_CLAMP: begin
        ram_we    = 1'b1;
        ram_waddr = ram_raddr;
        ram_wdata = k_clamped;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign target3 = (int'(item.finger) == pfsa_pkg::THUMB_FINGER)
                   ? ({2'b00, force_setpoint} + {1'b0, force_setpoint, 1'b0})
                   : {2'b00, force_setpoint};

  // Arithmetic shift floors the signed Q35.16 product to a Q35.0 adjustment.
  assign adj   = pfsa_pkg::ADJ_W'(prod >>> 16);
  assign k_sum = $signed({2'b00, ram_rdata}) + pfsa_pkg::SUM_W'(adj);

  always_comb begin
    if (k_sum < 0) begin
      k_clamped = '0;
    end else if (k_sum > $signed({2'b00, kmax})) begin
      k_clamped = kmax;
    end else begin
      k_clamped = k_sum[pfsa_pkg::STIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag <= 1'b0;
      sweep_cnt   <= '0;
    end else begin
      if (in_fire && in_item.operation == pfsa_pkg::OP_ACTIVITY) begin
        active_flag <= in_item.activate;
        sweep_cnt   <= '0;
      end else if (state == pfsa_pkg::S_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_item;
    end
    case (state)
      pfsa_pkg::S_SWEEP: begin
        res.all_fingers     <= 1'b1;
        res.finger_out      <= 2'd0;
        res.stiffness       <= pfsa_pkg::STIFF_W'(initial_stiffness);
        res.spring_active   <= active_flag;
        res.force_magnitude <= '0;
      end
      pfsa_pkg::S_SQUARE: begin
        sq_x <= (2*pfsa_pkg::FORCE_W-1)'(item.force_x * item.force_x);
        sq_y <= (2*pfsa_pkg::FORCE_W-1)'(item.force_y * item.force_y);
        sq_z <= (2*pfsa_pkg::FORCE_W-1)'(item.force_z * item.force_z);
      end
      pfsa_pkg::S_SUM: begin
        sum_sq <= pfsa_pkg::SQ_W'(sq_x) + pfsa_pkg::SQ_W'(sq_y) + pfsa_pkg::SQ_W'(sq_z);
      end
      pfsa_pkg::S_SQRT: begin
        if (sqrt_done) begin
          mag <= sqrt_root;
          err <= $signed({1'b0, target3}) - $signed({3'b000, sqrt_root});
        end
      end
      pfsa_pkg::S_MUL: begin
        prod <= err * adapt_gain;
        kmax <= {3'b000, initial_stiffness} + {1'b0, initial_stiffness, 2'b00};
      end
      pfsa_pkg::S_CLAMP: begin
        res.all_fingers     <= 1'b0;
        res.finger_out      <= item.finger;
        res.stiffness       <= k_clamped;
        res.spring_active   <= 1'b1;
        res.force_magnitude <= mag;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pfsa_pkg::S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pfsa_pkg::S_EMIT && out_free) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    sqrt_done && state == pfsa_pkg::S_SQRT |->
      (34'(sqrt_root) * 34'(sqrt_root) <= 34'(sum_sq)) &&
      ((34'(sqrt_root) + 34'd1) * (34'(sqrt_root) + 34'd1) > 34'(sum_sq)))
    else $error("square root result is not the floor root of the sum of squares");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    state == pfsa_pkg::S_CLAMP |-> ram_wdata <= kmax)
    else $error("stiffness written above five times the initial stiffness");

  a_activity_sweep: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_item.operation == pfsa_pkg::OP_ACTIVITY |=>
      state == pfsa_pkg::S_SWEEP && sweep_cnt == '0 &&
      active_flag == $past(in_item.activate))
    else $error("activity request did not start the reload sweep");

  a_ram_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == pfsa_pkg::S_SWEEP || state == pfsa_pkg::S_CLAMP)
    else $error("stiffness RAM written outside sweep or update");

  a_all_fingers_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.all_fingers |->
      out_item.finger_out == 2'd0 && out_item.force_magnitude == '0)
    else $error("all-finger command carries finger or magnitude");
`endif

endmodule
